/* rtl/cbf_pkg.sv */
// Shared constants and types for the counting Bloom filter block.
// Used by cbf_table, cbf_ctrl and counting_bloom_insert_if_absent; depends on nothing.
package cbf_pkg;

  localparam int INDEX_BITS    = 16;
  localparam int COUNTER_WIDTH = 16;
  localparam int TABLE_DEPTH   = 1 << INDEX_BITS;
  localparam int HASH_WIDTH    = 32;
  localparam int TOTAL_WIDTH   = 32;
  localparam int NUM_PROBES    = 4;
  localparam int PROBE_BITS    = 2;

  typedef logic [INDEX_BITS-1:0]    index_t;
  typedef logic [COUNTER_WIDTH-1:0] counter_t;
  typedef logic [HASH_WIDTH-1:0]    hash_t;
  typedef logic [TOTAL_WIDTH-1:0]   total_t;
  typedef logic [PROBE_BITS-1:0]    probe_t;
  // Number of probes so far that hit the same index, 1 up to NUM_PROBES.
  typedef logic [PROBE_BITS:0]      inc_t;

  localparam probe_t PROBE_LAST = probe_t'(NUM_PROBES - 1);

  // One access to the counter memory.
  typedef struct packed {
    logic     en;
    logic     we;
    index_t   addr;
    counter_t wdata;
  } mem_req_t;

  // One finished result word.
  typedef struct packed {
    logic   was_present;
    total_t present_total;
    total_t absent_total;
  } result_t;

endpackage

/* rtl/cbf_table.sv */
// Single-ported counter memory with registered read and a clearing pass.
// Depends on cbf_pkg.
module cbf_table (
  input  logic               clk,
  input  logic               rst_n,
  input  cbf_pkg::mem_req_t  req,
  output cbf_pkg::counter_t  rdata,
  output logic               ready
);

  cbf_pkg::counter_t mem_r [cbf_pkg::TABLE_DEPTH];
  cbf_pkg::counter_t rdata_r;
  cbf_pkg::index_t   clr_addr_r;
  logic              clearing_r;

  // Clearing pass: after reset every entry is written to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + cbf_pkg::index_t'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Memory array: one write or one read per cycle.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (req.en && req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
  end

  // Registered read data.
  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      rdata_r <= mem_r[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign ready = !clearing_r;

endmodule

/* rtl/cbf_ctrl.sv */
// Sequencer for the counting Bloom filter: probes the table, decides, writes back.
// Depends on cbf_pkg; drives the cbf_table port.
module cbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbf_pkg::hash_t     in_hash_word0,
  input  cbf_pkg::hash_t     in_hash_word1,
  input  cbf_pkg::hash_t     in_hash_word2,
  input  cbf_pkg::hash_t     in_hash_word3,
  output cbf_pkg::mem_req_t  mem_req,
  input  cbf_pkg::counter_t  mem_rdata,
  input  logic               mem_ready,
  output logic               res_valid,
  output cbf_pkg::result_t   res,
  input  logic               res_free
);

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EVAL, ST_WR, ST_HOLD} state_t;

  state_t            state_r;
  cbf_pkg::probe_t   cnt_r;
  logic              pres_r;
  cbf_pkg::total_t   present_r;
  cbf_pkg::total_t   absent_r;
  cbf_pkg::index_t   idx_r  [cbf_pkg::NUM_PROBES];
  cbf_pkg::counter_t orig_r [cbf_pkg::NUM_PROBES];

  cbf_pkg::hash_t    hash_w [cbf_pkg::NUM_PROBES];
  cbf_pkg::inc_t     inc    [cbf_pkg::NUM_PROBES];
  logic              accept;
  logic              eval;
  logic              all_set;
  logic              finish;
  logic              was_nxt;
  cbf_pkg::total_t   present_nxt;
  cbf_pkg::total_t   absent_nxt;

  assign hash_w[0] = in_hash_word0;
  assign hash_w[1] = in_hash_word1;
  assign hash_w[2] = in_hash_word2;
  assign hash_w[3] = in_hash_word3;

  // Input handshake: one word at a time, none while the table is being cleared.
  assign in_stall = (state_r != ST_IDLE) || !mem_ready;
  assign accept   = in_valid && !in_stall;

  // The last probe's counter arrives from the memory in the decision cycle.
  assign eval    = (state_r == ST_EVAL);
  assign all_set = (orig_r[0] != '0) && (orig_r[1] != '0) && (orig_r[2] != '0) &&
                   (mem_rdata != '0);

  // Per probe, the number of probes up to and including it with the same index.
  // Writes go in probe order, so the last write to a repeated index carries the full sum.
  always_comb begin
    for (int k = 0; k < cbf_pkg::NUM_PROBES; k++) begin
      inc[k] = '0;
      for (int j = 0; j <= k; j++) begin
        if (idx_r[j] == idx_r[k]) begin
          inc[k] = inc[k] + cbf_pkg::inc_t'(1);
        end
      end
    end
  end

  // Memory access for the current step.
  always_comb begin
    mem_req = '0;
    case (state_r)
      ST_RD: begin
        mem_req.en   = 1'b1;
        mem_req.addr = idx_r[cnt_r];
      end
      ST_EVAL: begin
        if (!all_set) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = idx_r[0];
          mem_req.wdata = orig_r[0] + cbf_pkg::counter_t'(inc[0]);
        end
      end
      ST_WR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = idx_r[cnt_r];
        mem_req.wdata = orig_r[cnt_r] + cbf_pkg::counter_t'(inc[cnt_r]);
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Result word and running totals.
  assign finish      = (eval && all_set) || ((state_r == ST_WR) && (cnt_r == cbf_pkg::PROBE_LAST)) ||
                       (state_r == ST_HOLD);
  assign res_valid   = finish && res_free;
  assign was_nxt     = eval ? all_set : pres_r;
  assign present_nxt = present_r + cbf_pkg::total_t'(eval && all_set);
  assign absent_nxt  = absent_r + cbf_pkg::total_t'(eval && !all_set);
  assign res         = '{was_present: was_nxt, present_total: present_nxt,
                         absent_total: absent_nxt};

  // Sequencer state, probe counter and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pres_r    <= 1'b0;
      present_r <= '0;
      absent_r  <= '0;
    end else begin
      present_r <= present_nxt;
      absent_r  <= absent_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cnt_r   <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          cnt_r <= cnt_r + cbf_pkg::probe_t'(1);
          if (cnt_r == cbf_pkg::PROBE_LAST) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          pres_r <= all_set;
          if (all_set) begin
            state_r <= res_free ? ST_IDLE : ST_HOLD;
          end else begin
            cnt_r   <= cbf_pkg::probe_t'(1);
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          if (cnt_r == cbf_pkg::PROBE_LAST) begin
            state_r <= res_free ? ST_IDLE : ST_HOLD;
          end else begin
            cnt_r <= cnt_r + cbf_pkg::probe_t'(1);
          end
        end
        ST_HOLD: begin
          if (res_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Probe indices and the counters read for them.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < cbf_pkg::NUM_PROBES; k++) begin
        idx_r[k] <= hash_w[k][cbf_pkg::INDEX_BITS-1:0];
      end
    end
    if ((state_r == ST_RD) && (cnt_r != '0)) begin
      orig_r[cnt_r - cbf_pkg::probe_t'(1)] <= mem_rdata;
    end
    if (eval) begin
      orig_r[cbf_pkg::PROBE_LAST] <= mem_rdata;
    end
  end

  // An accepted word starts with the first probe read.
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RD) && (cnt_r == '0))
    else $error("accepted word did not start probing");

  // Each decision moves exactly one of the two totals by one.
  a_one_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
    eval |=> (present_r + absent_r) == ($past(present_r) + $past(absent_r) + 32'd1))
    else $error("totals did not advance by one");

  // Counters are written back only for a word found absent.
  a_write_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.en && mem_req.we) |-> ((eval && !all_set) || ((state_r == ST_WR) && !pres_r)))
    else $error("counter written for a present word");

  // Nothing is taken in while the clearing pass runs.
  a_stall_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> in_stall)
    else $error("input taken during clearing pass");

endmodule

/* rtl/counting_bloom_insert_if_absent.sv */
// Counting Bloom filter, test and insert on miss: top level with the output register.
// Depends on cbf_pkg, cbf_table and cbf_ctrl.
// Each word is handled whole before the next is taken: four probe reads, then, for a word
// found absent, four counter writes, all through the single memory port; the result
// then waits in the controller while the output register is full and stalled.
// Reset: synchronous; then a clearing pass zeroes all 65536 table entries, input stalled.
module counting_bloom_insert_if_absent (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cbf_pkg::hash_t   in_hash_word0,
  input  cbf_pkg::hash_t   in_hash_word1,
  input  cbf_pkg::hash_t   in_hash_word2,
  input  cbf_pkg::hash_t   in_hash_word3,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_was_present,
  output cbf_pkg::total_t  out_present_total,
  output cbf_pkg::total_t  out_absent_total
);

  cbf_pkg::mem_req_t mem_req;
  cbf_pkg::counter_t mem_rdata;
  logic              mem_ready;
  logic              res_valid;
  logic              res_free;
  cbf_pkg::result_t  res;
  cbf_pkg::result_t  out_r;
  logic              out_valid_r;

  cbf_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  cbf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hash_word0 (in_hash_word0),
    .in_hash_word1 (in_hash_word1),
    .in_hash_word2 (in_hash_word2),
    .in_hash_word3 (in_hash_word3),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .mem_ready     (mem_ready),
    .res_valid     (res_valid),
    .res           (res),
    .res_free      (res_free)
  );

  // The output register can take a new word when empty or being emptied.
  assign res_free = !out_valid_r || !out_stall;

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_was_present   = out_r.was_present;
  assign out_present_total = out_r.present_total;
  assign out_absent_total  = out_r.absent_total;

endmodule
